// ----- hdl/mlbd_pkg.sv -----
// shared types and constants of the mip level box downsampler
package mlbd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int ROW_LIMIT     = 4096;
  localparam int SIZE_W        = 13;
  localparam int ROW_W         = 12;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       level_done;
  } pixel_out_t;

  // four 9-bit channel sums of a horizontal pixel pair
  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
    logic [8:0] a;
  } quad_sum_t;

endpackage

// ----- hdl/mip_level_box_downsample_top.sv -----
// top level of the 2x2 box filter mip downsampler for rgba8 pixels
//
// pixels of one mip level come in raster order, one beat per clock unless
// in_stall holds them, and the block emits the next smaller level: each
// result beat is the truncated mean of a 2x2 block per channel, emitted with
// the bottom-right pixel of the block. a trailing odd column or row is
// dropped. throughput is one pixel per cycle while in_stall is low; a result
// passes the ram read and stage 1, then the output register. the line store
// has one write and one read port: even rows write pair sums, odd rows read
// them, so no entry is read and written at once. the ram has no reset and no
// clearing pass; it is always written by an even row before the odd row
// reads it. start_of_image restarts the column and row counters; at the end
// of a level they wrap by themselves. width and height are written over apb
// (width at 0x0, height at 0x4), by the user only while the block is idle;
// the block does not enforce it. 0 acts as 1, sizes above limits are clamped.
module mip_level_box_downsample_top #(
  parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mlbd_pkg::pixel_in_t          in_data,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output mlbd_pkg::pixel_out_t         out_data,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlbd_pkg::APB_AW-1:0]  paddr,
  input  logic [mlbd_pkg::APB_DW-1:0]  pwdata,
  output logic [mlbd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import mlbd_pkg::*;

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);        // column counter
  localparam int WW    = $clog2(MAX_WIDTH + 1);    // clamped width
  localparam int CMPW  = (WW > SIZE_W) ? WW : SIZE_W;

  // configuration registers
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(MAX_WIDTH_DEF);
      height_r <= SIZE_W'(ROW_LIMIT);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = APB_DW'(width_r);
      REG_HEIGHT: prdata = APB_DW'(height_r);
      default:    prdata = '0;
    endcase
  end

  // clamped sizes and the even-rounded used region
  logic [CMPW-1:0]   width_ext;
  logic [WW-1:0]     width_c;
  logic [WW-1:0]     width_even;
  logic [SIZE_W-1:0] height_c;
  logic [SIZE_W-1:0] height_even;

  assign width_ext = CMPW'(width_r);

  always_comb begin
    if (width_ext == '0) begin
      width_c = WW'(1);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      width_c = WW'(MAX_WIDTH);
    end else begin
      width_c = width_ext[WW-1:0];
    end
    if (height_r == '0) begin
      height_c = SIZE_W'(1);
    end else if (height_r > SIZE_W'(ROW_LIMIT)) begin
      height_c = SIZE_W'(ROW_LIMIT);
    end else begin
      height_c = height_r;
    end
  end

  assign width_even  = {width_c[WW-1:1], 1'b0};
  assign height_even = {height_c[SIZE_W-1:1], 1'b0};

  // pipeline control: stage 1 waits on the ram read, then the output register
  logic s1_valid_r;
  logic out_valid_r;
  logic out_free;
  logic accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  // position of the current beat
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [CW-1:0]    col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [WW-1:0]    col_ext;
  logic [SIZE_W-1:0] row_ext;
  logic [WW-1:0]    col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic             in_region;
  logic             block_last;
  logic [CW-1:0]    col_half;
  logic [AW-1:0]    slot;

  assign col_cur = in_data.start_of_image ? '0 : col_r;
  assign row_cur = in_data.start_of_image ? '0 : row_r;
  assign col_ext = WW'(col_cur);
  assign row_ext = SIZE_W'(row_cur);
  assign col_inc = col_ext + WW'(1);
  assign row_inc = row_ext + SIZE_W'(1);

  assign in_region  = (col_ext < width_even) && (row_ext < height_even);
  assign block_last = (col_ext == width_even - WW'(1)) &&
                      (row_ext == height_even - SIZE_W'(1));
  assign col_half   = col_cur >> 1;
  assign slot       = col_half[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_inc >= width_c) begin
        col_r <= '0;
        // a row beyond a shrunken height wraps as well
        if (row_inc >= height_c) begin
          row_r <= '0;
        end else begin
          row_r <= row_inc[ROW_W-1:0];
        end
      end else begin
        col_r <= col_inc[CW-1:0];
        row_r <= row_cur;
      end
    end
  end

  // horizontal pair: held even-column pixel plus the current one
  quad_sum_t held_r;
  quad_sum_t pair_sum;

  assign pair_sum.r = held_r.r + {1'b0, in_data.red_in};
  assign pair_sum.g = held_r.g + {1'b0, in_data.green_in};
  assign pair_sum.b = held_r.b + {1'b0, in_data.blue_in};
  assign pair_sum.a = held_r.a + {1'b0, in_data.alpha_in};

  logic do_hold;
  logic do_store;
  logic do_emit;

  assign do_hold  = accept && in_region && !col_cur[0];
  assign do_store = accept && in_region && col_cur[0] && !row_cur[0];
  assign do_emit  = accept && in_region && col_cur[0] && row_cur[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (do_hold) begin
      held_r.r <= {1'b0, in_data.red_in};
      held_r.g <= {1'b0, in_data.green_in};
      held_r.b <= {1'b0, in_data.blue_in};
      held_r.a <= {1'b0, in_data.alpha_in};
    end
  end

  // line store: even rows write, odd rows read
  quad_sum_t rd_sum;

  mlbd_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (do_store),
    .wr_addr (slot),
    .wr_data (pair_sum),
    .rd_en   (do_emit),
    .rd_addr (slot),
    .rd_data (rd_sum)
  );

  // stage 1: lower pair sum and last flag wait for the ram data
  quad_sum_t s1_pair_r;
  logic      s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (do_emit) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      s1_pair_r <= pair_sum;
      s1_last_r <= block_last;
    end
  end

  // block mean, truncated
  function automatic logic [7:0] mean4(input logic [8:0] upper, input logic [8:0] lower);
    logic [9:0] total;
    total = {1'b0, upper} + {1'b0, lower};
    return total[9:2];
  endfunction

  pixel_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_r.red_out    <= mean4(rd_sum.r, s1_pair_r.r);
      out_r.green_out  <= mean4(rd_sum.g, s1_pair_r.g);
      out_r.blue_out   <= mean4(rd_sum.b, s1_pair_r.b);
      out_r.alpha_out  <= mean4(rd_sum.a, s1_pair_r.a);
      out_r.level_done <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/mlbd_line_store.sv -----
// line store ram holding the pair sums of an even row
module mlbd_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  mlbd_pkg::quad_sum_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output mlbd_pkg::quad_sum_t rd_data
);
  import mlbd_pkg::*;

  quad_sum_t mem [DEPTH];
  quad_sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- dv/mip_level_box_downsample_top_test.sv -----
// self-checking testbench of the mip level box downsampler, predicted 2x2 means against result beats
module mip_level_box_downsample_top_test;
  import mlbd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int STORE_DEPTH   = MAX_WIDTH_DEF / 2;
  // random phases run until this many pixels have gone in over the whole test
  localparam int PIXEL_BUDGET  = 850;
  localparam int HOLD_CYCLES   = 300;
  // results pass the ram read, stage 1 and the output register, so this covers any straggler
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  // predicts the means of each 2x2 block and holds them until their result beat turns up
  class box_mean_board;
    pixel_out_t        pending_means[$];
    quad_sum_t         pair_line[STORE_DEPTH];
    quad_sum_t         held_pair;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    int                mismatches;
    int                taken_pixels;

    function new();
      width_reg    = SIZE_W'(MAX_WIDTH_DEF);
      height_reg   = SIZE_W'(ROW_LIMIT);
      held_pair    = '0;
      col_pos      = 0;
      row_pos      = 0;
      mismatches   = 0;
      taken_pixels = 0;
    endfunction

    // zero acts as one, oversize values are clamped
    function int unsigned bounded_size(logic [SIZE_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cols();
      return bounded_size(width_reg, MAX_WIDTH_DEF);
    endfunction

    function int unsigned rows();
      return bounded_size(height_reg, ROW_LIMIT);
    endfunction

    function int unsigned level_pixels();
      return cols() * rows();
    endfunction

    function void set_reg(logic idx, logic [SIZE_W-1:0] v);
      if (idx == REG_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    // true where a resize without restart keeps every line store read behind a write
    function bit can_resize(bit width_too);
      if (col_pos == 0 && row_pos % 2 == 0) return 1'b1;
      if (width_too) return 1'b0;
      return row_pos < 2 * (rows() / 2);
    endfunction

    function logic [7:0] quarter(int unsigned a, int unsigned b, int unsigned c);
      return 8'((a + b + c) / 4);
    endfunction

    function void take_pixel(pixel_in_t p);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      pixel_out_t  m;
      w = cols();
      h = rows();
      taken_pixels++;
      if (p.start_of_image) begin
        col_pos = 0;
        row_pos = 0;
      end
      if (col_pos < 2 * (w / 2) && row_pos < 2 * (h / 2)) begin
        slot = (col_pos / 2) % STORE_DEPTH;
        if (col_pos % 2 == 0) begin
          held_pair.r = p.red_in;
          held_pair.g = p.green_in;
          held_pair.b = p.blue_in;
          held_pair.a = p.alpha_in;
        end else if (row_pos % 2 == 0) begin
          pair_line[slot].r = held_pair.r + p.red_in;
          pair_line[slot].g = held_pair.g + p.green_in;
          pair_line[slot].b = held_pair.b + p.blue_in;
          pair_line[slot].a = held_pair.a + p.alpha_in;
        end else begin
          m.red_out    = quarter(pair_line[slot].r, held_pair.r, p.red_in);
          m.green_out  = quarter(pair_line[slot].g, held_pair.g, p.green_in);
          m.blue_out   = quarter(pair_line[slot].b, held_pair.b, p.blue_in);
          m.alpha_out  = quarter(pair_line[slot].a, held_pair.a, p.alpha_in);
          m.level_done = (col_pos / 2 == w / 2 - 1) && (row_pos / 2 == h / 2 - 1);
          pending_means.push_back(m);
        end
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_mean(pixel_out_t got);
      pixel_out_t want;
      if (pending_means.size() == 0) begin
        $display("%0t: result beat expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_means.pop_front();
      check_field("red_out", want.red_out, got.red_out);
      check_field("green_out", want.green_out, got.green_out);
      check_field("blue_out", want.blue_out, got.blue_out);
      check_field("alpha_out", want.alpha_out, got.alpha_out);
      check_field("level_done", 8'(want.level_done), 8'(got.level_done));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pixel_in_t           in_data;
  logic                out_valid;
  logic                out_stall;
  pixel_out_t          out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // calm phases drop the idling on one side, hold_req asks the sink for a long hold-off
  bit                  in_calm;
  bit                  out_calm;
  bit                  hold_req;
  int unsigned         cycle_count = 0;
  box_mean_board       board;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  mip_level_box_downsample_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // channel values lean towards the extremes now and then
  function automatic logic [7:0] random_channel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic pixel_in_t random_pixel(bit soi);
    pixel_in_t p;
    p.start_of_image = soi;
    p.red_in         = random_channel();
    p.green_in       = random_channel();
    p.blue_in        = random_channel();
    p.alpha_in       = random_channel();
    return p;
  endfunction

  function automatic pixel_in_t make_pixel(bit soi, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b, logic [7:0] a);
    pixel_in_t p;
    p.start_of_image = soi;
    p.red_in         = r;
    p.green_in       = g;
    p.blue_in        = b;
    p.alpha_in       = a;
    return p;
  endfunction

  // timeout guard on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mip_level_box_downsample_top regression: fail");
      $finish;
    end
  end

  // result beats are taken where valid is high and stall low at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.match_mean(out_data);
  end

  // result sink: stall stretches of random length, or one long hold-off on request
  initial begin : result_sink
    int unsigned len;
    bit          stall_now;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_now = 1'b1;
        len       = HOLD_CYCLES;
      end else if (out_calm) begin
        stall_now = 1'b0;
        len       = 1;
      end else begin
        stall_now = ($urandom_range(0, 2) == 0);
        len       = stall_now ? idle_len() + 1 : $urandom_range(1, 8);
      end
      out_stall <= stall_now;
      repeat (len) @(negedge clk);
    end
  end

  // entered at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_pixel(pixel_in_t p);
    int unsigned gap;
    gap = in_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    board.take_pixel(p);
    @(negedge clk);
  endtask

  // noise adds a stray start_of_image now and then, cutting the level short
  task automatic send_random(int unsigned n, bit soi_first, bit noise);
    bit soi;
    for (int unsigned k = 0; k < n; k++) begin
      soi = (k == 0 && soi_first) || (noise && $urandom_range(0, 99) == 0);
      send_pixel(random_pixel(soi));
    end
  endtask

  // waits until every predicted beat has arrived, then lets the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write with random upper data bits, then a read back of the same register
  task automatic apb_access(logic idx, logic [SIZE_W-1:0] value);
    logic [APB_DW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~32'h1fff) | APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== APB_DW'(value)) begin
      $display("%0t: register %0d read expected %h, actual %h", $time, idx,
               APB_DW'(value), readback);
      board.mismatches++;
    end
    // an idle gap before the next transfer
    @(negedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    apb_access(REG_WIDTH, w);
    apb_access(REG_HEIGHT, h);
  endtask

  // one random phase: small sizes, one to three levels, some cut short
  task automatic random_phase();
    logic [SIZE_W-1:0] new_w;
    logic [SIZE_W-1:0] new_h;
    bit                width_too;
    bit                restart;
    int unsigned       count;
    new_w     = ($urandom_range(0, 19) == 0) ? '0 : SIZE_W'($urandom_range(1, 12));
    new_h     = ($urandom_range(0, 19) == 0) ? '0 : SIZE_W'($urandom_range(1, 8));
    width_too = $urandom_range(0, 1);
    in_calm   = ($urandom_range(0, 3) == 0);
    out_calm  = ($urandom_range(0, 3) == 0);
    // a third of the phases resize mid level and carry on without a restart,
    // but only where each odd row still finds its even row in the line store
    restart = !($urandom_range(0, 2) == 0 && board.can_resize(width_too));
    if (restart || width_too) apb_access(REG_WIDTH, new_w);
    apb_access(REG_HEIGHT, new_h);
    // later levels follow on the counter wrap, without start_of_image
    count = $urandom_range(1, 3) * board.level_pixels();
    if ($urandom_range(0, 6) == 0) count = $urandom_range(1, count);
    send_random(count, restart, 1'b1);
    drain();
  endtask

  initial begin : stimulus
    board    = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_calm  = 1'b0;
    out_calm = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset sizes are 4096 x 4096, so a few pixels of row 0 give no beat
    send_random(4, 1'b1, 1'b0);
    drain();

    // 4 x 2 level with extreme channels: full scale block, then truncation of small sums
    set_size(13'd4, 13'd2);
    send_pixel(make_pixel(1'b1, 8'hff, 8'hff, 8'h00, 8'h80));
    send_pixel(make_pixel(1'b0, 8'hff, 8'hff, 8'h00, 8'h7f));
    send_pixel(make_pixel(1'b0, 8'h00, 8'h01, 8'hff, 8'h00));
    send_pixel(make_pixel(1'b0, 8'h00, 8'h02, 8'hff, 8'hff));
    send_pixel(make_pixel(1'b0, 8'hff, 8'hff, 8'h00, 8'h80));
    send_pixel(make_pixel(1'b0, 8'hff, 8'hff, 8'h00, 8'h7f));
    send_pixel(make_pixel(1'b0, 8'h00, 8'h03, 8'hff, 8'h01));
    send_pixel(make_pixel(1'b0, 8'h03, 8'h00, 8'hfe, 8'hff));
    // next level rides on the counter wrap, no start_of_image
    send_random(8, 1'b0, 1'b0);
    drain();

    // zero width acts as one and zero height as one: empty output levels
    set_size(13'd0, 13'd4);
    send_random(2, 1'b1, 1'b0);
    drain();
    set_size(13'd5, 13'd0);
    send_random(3, 1'b1, 1'b0);
    drain();

    // long hold-off at the sink while the source keeps offering beats
    set_size(13'd8, 13'd8);
    in_calm  = 1'b1;
    out_calm = 1'b1;
    hold_req = 1'b1;
    send_random(128, 1'b1, 1'b0);
    drain();

    while (board.taken_pixels < PIXEL_BUDGET) random_phase();

    if (board.mismatches == 0 && board.pending_means.size() == 0) begin
      $display("mip_level_box_downsample_top regression: pass");
    end else begin
      $display("mip_level_box_downsample_top regression: fail");
    end
    $finish;
  end

endmodule
